// ===== sv/mlpsig_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpsig_pkg
// Shared types, codes and the sigmoid lookup table for the MLP inference unit.
// ----------------------------------------------------------------------------
package mlpsig_pkg;

  // Fixed-point format of weights, biases and activations.
  localparam int FRAC_BITS = 12;
  localparam int VAL_W     = 16;
  localparam int SIG_W     = FRAC_BITS + 1;
  localparam int TAB_SIZE  = 256;
  localparam int TAB_IDX_W = 8;

  // Command codes.
  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LAYERS = 3'd0;
  localparam logic [2:0] CFG_WIDTH0 = 3'd1;
  localparam logic [2:0] CFG_WIDTH1 = 3'd2;
  localparam logic [2:0] CFG_WIDTH2 = 3'd3;
  localparam logic [2:0] CFG_WIDTH3 = 3'd4;

  // Control from the sequencer to the neuron datapath.
  typedef struct packed {
    logic issue;   // weight/activation read issued this cycle
    logic first;   // the issued read is the first column of a row
    logic round;   // accumulator is final: round, saturate and index
  } dp_ctrl_t;

  typedef logic [SIG_W-1:0] sig_tab_t [TAB_SIZE];

  // Builds the sigmoid table at elaboration. Entry i approximates
  // sigmoid((i-128)/16) in Q0.FRAC_BITS, using a Q32 power series of e^(-1/16)
  // and a rounded long division.
  function automatic sig_tab_t build_sig_table();
    logic [63:0] p [129];
    logic [95:0] prod;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    sig_tab_t    tab;
    int          k;
    int          i;
    int          b;
    p[0] = 64'h1_0000_0000;
    for (k = 0; k < 128; k++) begin
      prod = {32'd0, p[k]} * 96'd4034748382 + (96'd1 << 31);
      p[k+1] = prod[95:32];
    end
    for (i = 0; i < TAB_SIZE; i++) begin
      if (i >= 128) begin
        d   = 64'h1_0000_0000 + p[i-128];
        num = 64'd1 << (FRAC_BITS + 32);
      end else begin
        d   = 64'h1_0000_0000 + p[128-i];
        num = p[128-i] << FRAC_BITS;
      end
      num = num + (d >> 1);
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= d) begin
          rem    = rem - d;
          quo[b] = 1'b1;
        end
      end
      tab[i] = quo[SIG_W-1:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

// ===== sv/mlpsig_dp.sv =====
// ----------------------------------------------------------------------------
// mlpsig_dp
// Neuron datapath: registered multiply, accumulate with bias, rounding and
// saturation to Q4.12, and sigmoid table lookup.
// ----------------------------------------------------------------------------
module mlpsig_dp #(
  parameter int MAX_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mlpsig_pkg::dp_ctrl_t                  ctrl,
  input  logic signed [mlpsig_pkg::VAL_W-1:0]   w_q,
  input  logic signed [mlpsig_pkg::VAL_W-1:0]   a_q,
  input  logic signed [mlpsig_pkg::VAL_W-1:0]   b_q,
  output logic        [mlpsig_pkg::SIG_W-1:0]   sig_value
);

  localparam int ACC_W  = 2 * mlpsig_pkg::VAL_W + $clog2(MAX_WIDTH) + 2;
  localparam int PROD_W = 2 * mlpsig_pkg::VAL_W;
  localparam int FB     = mlpsig_pkg::FRAC_BITS;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FB - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -ACC_W'(32768);

  logic                              iss_d_r;
  logic                              first_d_r;
  logic                              prod_vld_r;
  logic signed [PROD_W-1:0]          prod_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic [mlpsig_pkg::TAB_IDX_W-1:0]  idx_r;

  logic signed [ACC_W-1:0]           rnd_sum;
  logic signed [ACC_W-1:0]           x_full;
  logic signed [15:0]                x_sat;
  logic signed [15:0]                x_shr;
  logic signed [16:0]                idx_s;
  logic [mlpsig_pkg::TAB_IDX_W-1:0]  idx_c;

  // Track read data validity two stages down the multiply pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_d_r    <= 1'b0;
      first_d_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      iss_d_r    <= ctrl.issue;
      first_d_r  <= ctrl.issue & ctrl.first;
      prod_vld_r <= iss_d_r;
    end
  end

  // Product register, then accumulator seeded with the scaled bias.
  always_ff @(posedge clk) begin
    if (iss_d_r) begin
      prod_r <= w_q * a_q;
    end
    if (first_d_r) begin
      acc_r <= ACC_W'(b_q) <<< FB;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Round to nearest (half up), saturate to 16 bits, form the table index.
  always_comb begin
    rnd_sum = acc_r + RND_HALF;
    x_full  = rnd_sum >>> FB;
    if (x_full > SAT_MAX) begin
      x_sat = 16'sh7FFF;
    end else if (x_full < SAT_MIN) begin
      x_sat = -16'sh8000;
    end else begin
      x_sat = x_full[15:0];
    end
    x_shr = x_sat >>> (FB - 4);
    idx_s = {x_shr[15], x_shr} + 17'sd128;
    if (idx_s < 17'sd0) begin
      idx_c = '0;
    end else if (idx_s > 17'sd255) begin
      idx_c = '1;
    end else begin
      idx_c = idx_s[mlpsig_pkg::TAB_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.round) begin
      idx_r <= idx_c;
    end
  end

  assign sig_value = mlpsig_pkg::SIG_TABLE[idx_r];

endmodule

// ===== sv/mlp_sigmoid_inference_unit.sv =====
// ----------------------------------------------------------------------------
// mlp_sigmoid_inference_unit
// Dense multilayer perceptron with sigmoid activation, Q4.12 fixed point.
// Weights, biases and activations live in on-chip memories; one shared
// multiply-accumulate unit walks every neuron of every layer in turn.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ---------------------------------------
//  input     start & !busy             in_opcode in_layer_sel in_row in_col
//                                      in_value in_last
//  result    out_strobe (one cycle)    out_index out_value out_last
//  config    cfg_valid & cfg_ready     cfg_index cfg_data
//
//  Weight, bias and non-final sample transactions are accepted without raising busy.
//  A final sample runs inference: each neuron is computed in turn on the
//  single MAC unit, then one result per cycle streams out, read back from the
//  activation store through a registered read. busy stays high until the last result is read.
//  Reset is synchronous; it restores the configuration registers and the
//  sequencer. Memory contents are not cleared. Results cannot be stalled.
//
module mlp_sigmoid_inference_unit #(
  parameter int MAX_LAYERS = 4,
  parameter int MAX_WIDTH  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_opcode,
  input  logic [1:0]                            in_layer_sel,
  input  logic [3:0]                            in_row,
  input  logic [3:0]                            in_col,
  input  logic signed [mlpsig_pkg::VAL_W-1:0]   in_value,
  input  logic                                  in_last,
  // Result channel
  output logic                                  out_strobe,
  output logic [3:0]                            out_index,
  output logic [mlpsig_pkg::SIG_W-1:0]          out_value,
  output logic                                  out_last,
  // Configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [2:0]                            cfg_index,
  input  logic [7:0]                            cfg_data
);

  localparam int LMAX    = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
  localparam int CNT_W   = $clog2(MAX_WIDTH + 1);
  localparam int WDEPTH  = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
  localparam int BDEPTH  = (MAX_LAYERS - 1) * MAX_WIDTH;
  localparam int ADEPTH  = 2 * MAX_WIDTH;
  localparam int WADDR_W = $clog2(WDEPTH);
  localparam int BADDR_W = $clog2(BDEPTH);
  localparam int AADDR_W = $clog2(ADEPTH);
  localparam int VW      = mlpsig_pkg::VAL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_DRN1 = 3'd2;
  localparam logic [2:0] S_DRN2 = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // Clamp a configured width to [1, MAX_WIDTH].
  function automatic logic [CNT_W-1:0] clamp_w(input logic [4:0] w);
    if (w == 5'd0) begin
      return CNT_W'(1);
    end
    if (int'(w) > MAX_WIDTH) begin
      return CNT_W'(MAX_WIDTH);
    end
    return CNT_W'(w);
  endfunction

  // Configuration registers.
  logic [2:0] layer_count_r;
  logic [4:0] width_r [4];

  // Sequencer registers.
  logic [2:0]       state_r, state_nxt;
  logic [1:0]       t_r, t_nxt;
  logic [CNT_W-1:0] r_r, r_nxt;
  logic [CNT_W-1:0] c_r, c_nxt;

  // Result registers.
  logic       out_strobe_r, out_strobe_nxt;
  logic [3:0] out_index_r, out_index_nxt;
  logic       out_last_r, out_last_nxt;

  // Memories.
  logic signed [VW-1:0] wmem [WDEPTH];
  logic signed [VW-1:0] bmem [BDEPTH];
  logic signed [VW-1:0] amem [ADEPTH];
  logic signed [VW-1:0] w_q, b_q, a_q;

  logic                 accept;
  logic [2:0]           layers_w;
  logic                 last_trans;
  logic [CNT_W-1:0]     n_in_w;
  logic [CNT_W-1:0]     n_next_w;
  logic                 w_we, b_we, a_we;
  logic [WADDR_W-1:0]   w_waddr, w_raddr;
  logic [BADDR_W-1:0]   b_waddr, b_raddr;
  logic [AADDR_W-1:0]   a_waddr, a_raddr;
  logic signed [VW-1:0] a_wdata;
  logic [mlpsig_pkg::SIG_W-1:0] sig_value;
  mlpsig_pkg::dp_ctrl_t dp_ctrl;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= 3'd3;
      width_r[0]    <= 5'd16;
      width_r[1]    <= 5'd16;
      width_r[2]    <= 5'd16;
      width_r[3]    <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mlpsig_pkg::CFG_LAYERS: layer_count_r <= cfg_data[2:0];
        mlpsig_pkg::CFG_WIDTH0: width_r[0]    <= cfg_data[4:0];
        mlpsig_pkg::CFG_WIDTH1: width_r[1]    <= cfg_data[4:0];
        mlpsig_pkg::CFG_WIDTH2: width_r[2]    <= cfg_data[4:0];
        mlpsig_pkg::CFG_WIDTH3: width_r[3]    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Effective layer count and the widths of the current transition.
  always_comb begin
    if (layer_count_r < 3'd2) begin
      layers_w = 3'd2;
    end else if (int'(layer_count_r) > LMAX) begin
      layers_w = 3'(LMAX);
    end else begin
      layers_w = layer_count_r;
    end
  end

  assign n_in_w     = clamp_w(width_r[t_r]);
  assign n_next_w   = clamp_w(width_r[t_r + 2'd1]);
  assign last_trans = ({1'b0, t_r} + 3'd2) == layers_w;

  // Store writes from weight and bias transactions.
  assign w_we = accept && (in_opcode == mlpsig_pkg::OP_WEIGHT)
             && (int'(in_layer_sel) < MAX_LAYERS - 1)
             && (int'(in_row) < MAX_WIDTH) && (int'(in_col) < MAX_WIDTH);
  assign b_we = accept && (in_opcode == mlpsig_pkg::OP_BIAS)
             && (int'(in_layer_sel) < MAX_LAYERS - 1)
             && (int'(in_row) < MAX_WIDTH);
  assign w_waddr = WADDR_W'((int'(in_layer_sel) * MAX_WIDTH + int'(in_row)) * MAX_WIDTH
                            + int'(in_col));
  assign b_waddr = BADDR_W'(int'(in_layer_sel) * MAX_WIDTH + int'(in_row));

  // Sequencer read addresses.
  assign w_raddr = WADDR_W'((int'(t_r) * MAX_WIDTH + int'(r_r)) * MAX_WIDTH + int'(c_r));
  assign b_raddr = BADDR_W'(int'(t_r) * MAX_WIDTH + int'(r_r));

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= in_value;
    end
    w_q <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_waddr] <= in_value;
    end
    b_q <= bmem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    a_q <= amem[a_raddr];
  end

  // Neuron datapath.
  mlpsig_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (dp_ctrl),
    .w_q       (w_q),
    .a_q       (a_q),
    .b_q       (b_q),
    .sig_value (sig_value)
  );

  // Sequencer: per row, issue one column per cycle, drain the MAC pipe,
  // round, then write the activation into the other half of the store.
  always_comb begin
    state_nxt      = state_r;
    t_nxt          = t_r;
    r_nxt          = r_r;
    c_nxt          = c_r;
    out_strobe_nxt = 1'b0;
    out_index_nxt  = out_index_r;
    out_last_nxt   = 1'b0;
    dp_ctrl        = '0;
    a_we           = 1'b0;
    a_waddr        = AADDR_W'(in_col);
    a_wdata        = in_value;
    a_raddr        = AADDR_W'(int'(t_r[0]) * MAX_WIDTH + int'(c_r));
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_opcode == mlpsig_pkg::OP_SAMPLE)
            && (int'(in_col) < MAX_WIDTH)) begin
          a_we = 1'b1;
          if (in_last) begin
            state_nxt = S_MAC;
            t_nxt     = 2'd0;
            r_nxt     = '0;
            c_nxt     = '0;
          end
        end
      end
      S_MAC: begin
        dp_ctrl.issue = 1'b1;
        dp_ctrl.first = (c_r == '0);
        if (c_r == n_in_w - CNT_W'(1)) begin
          state_nxt = S_DRN1;
        end else begin
          c_nxt = c_r + CNT_W'(1);
        end
      end
      S_DRN1: begin
        state_nxt = S_DRN2;
      end
      S_DRN2: begin
        state_nxt = S_RND;
      end
      S_RND: begin
        dp_ctrl.round = 1'b1;
        state_nxt     = S_WR;
      end
      S_WR: begin
        a_we    = 1'b1;
        a_waddr = AADDR_W'(int'(!t_r[0]) * MAX_WIDTH + int'(r_r));
        a_wdata = VW'(sig_value);
        c_nxt   = '0;
        if (r_r == n_next_w - CNT_W'(1)) begin
          r_nxt     = '0;
          t_nxt     = t_r + 2'd1;
          state_nxt = last_trans ? S_OUT : S_MAC;
        end else begin
          r_nxt     = r_r + CNT_W'(1);
          state_nxt = S_MAC;
        end
      end
      S_OUT: begin
        a_raddr        = AADDR_W'(int'(t_r[0]) * MAX_WIDTH + int'(r_r));
        out_strobe_nxt = 1'b1;
        out_index_nxt  = 4'(r_r);
        if (r_r == n_in_w - CNT_W'(1)) begin
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          r_nxt = r_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      t_r          <= 2'd0;
      r_r          <= '0;
      c_r          <= '0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      t_r          <= t_nxt;
      r_r          <= r_nxt;
      c_r          <= c_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_index_r <= out_index_nxt;
  end

  // The activation read data lines up with the registered strobe.
  assign out_strobe = out_strobe_r;
  assign out_index  = out_index_r;
  assign out_last   = out_last_r;
  assign out_value  = a_q[mlpsig_pkg::SIG_W-1:0];

endmodule
